@@ src/gtm_pkg.sv @@
// Shared types and constants for the gesture template matcher.
// Used by every module of the block; depends on nothing.
package gtm_pkg;

	localparam int SEQ_LEN   = 50;
	localparam int IDX_W     = $clog2(SEQ_LEN);
	localparam int SAMPLE_W  = 16;
	localparam int ENTRY_W   = 3 * SAMPLE_W;
	localparam int TOTAL_W   = 12;
	localparam int OUT_IDX_W = 10;
	localparam int CFG_IDX_W = 1;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEQ_LEN - 1);

	typedef enum logic {
		FUNC_RECORD = 1'b0,
		FUNC_CHECK  = 1'b1
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOLERANCE   = 1'b0,
		REG_MIN_MATCHES = 1'b1
	} cfg_reg_t;

	// Word held between the accept stage and the scoring stage.
	typedef struct packed {
		logic                       compare;
		logic                       clear;
		logic [IDX_W-1:0]           idx;
		logic                       done;
		logic                       tready;
		logic signed [SAMPLE_W-1:0] x;
		logic signed [SAMPLE_W-1:0] y;
		logic signed [SAMPLE_W-1:0] z;
	} s1_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] sample_index;
		logic [1:0]           axes_matched;
		logic [TOTAL_W-1:0]   match_total;
		logic                 sequence_done;
		logic                 gesture_accepted;
		logic                 template_ready;
	} result_t;

endpackage

@@ src/gtm_template_mem.sv @@
// Template store: one entry of three packed 16-bit axes per sample position.
// Synchronous write, registered read; uses gtm_pkg.
module gtm_template_mem (
	input  logic                        clk,
	input  logic                        we,
	input  logic                        re,
	input  logic [gtm_pkg::IDX_W-1:0]   addr,
	input  logic [gtm_pkg::ENTRY_W-1:0] wdata,
	output logic [gtm_pkg::ENTRY_W-1:0] rdata
);
	import gtm_pkg::*;

	logic [ENTRY_W-1:0] mem [SEQ_LEN];
	logic [ENTRY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/gtm_score.sv @@
// Scoring stage: compares a sample with its template entry, keeps the running
// total and holds the output word. Uses gtm_pkg.
module gtm_score (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gtm_pkg::s1_t                s1,
	input  logic                        valid_s1,
	input  logic [gtm_pkg::ENTRY_W-1:0] entry,
	input  logic [15:0]                 tol,
	input  logic [gtm_pkg::TOTAL_W-1:0] min_matches,
	output logic                        adv,
	output logic                        out_valid,
	input  logic                        out_ready,
	output gtm_pkg::result_t            res
);
	import gtm_pkg::*;

	logic [TOTAL_W-1:0] run_q;
	logic               out_valid_q;
	result_t            res_q;
	logic [2:0]         close;
	logic [1:0]         axes;
	logic [TOTAL_W-1:0] total;
	logic [ENTRY_W-1:0] sample;

	assign sample = {s1.z, s1.y, s1.x};

	for (genvar k = 0; k < 3; k++) begin : g_axis
		logic signed [SAMPLE_W:0] diff;
		logic [SAMPLE_W:0]        mag;
		always_comb begin
			diff = (SAMPLE_W+1)'($signed(sample[k*SAMPLE_W +: SAMPLE_W]))
				- (SAMPLE_W+1)'($signed(entry[k*SAMPLE_W +: SAMPLE_W]));
			mag = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : diff;
		end
		assign close[k] = mag <= {1'b0, tol};
	end

	assign axes  = 2'(close[0]) + 2'(close[1]) + 2'(close[2]);
	assign total = (s1.clear ? '0 : run_q) + TOTAL_W'(axes);
	assign adv   = valid_s1 && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				run_q       <= (s1.compare && !s1.done) ? total : '0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.sample_index     <= OUT_IDX_W'(s1.idx);
			res_q.axes_matched     <= s1.compare ? axes : 2'd0;
			res_q.match_total      <= s1.compare ? total : '0;
			res_q.sequence_done    <= s1.done;
			res_q.gesture_accepted <= s1.compare && s1.done && (total >= min_matches);
			res_q.template_ready   <= s1.tready;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

@@ src/gesture_template_matcher_core.sv @@
// Top level of the gesture template matcher: accept stage, configuration
// registers, template memory and scoring stage. Uses gtm_pkg, gtm_template_mem
// and gtm_score.
//
//  channel | handshake            | word
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | func, first_sample, accel_x/y/z
//  out     | out_valid / out_ready| sample_index, axes_matched, match_total,
//          |                      | sequence_done, gesture_accepted,
//          |                      | template_ready
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// One word is accepted per cycle while the output is not stalled; its result is
// registered in two steps: the template memory read and the sample register load
// at acceptance, and the output register loads when the scoring stage advances.
// Position and template-valid update at acceptance; the running total updates
// in the scoring stage, so back-to-back words need no interlock.
// Reset clears position, running total, template-valid and loads the
// configuration defaults; the template memory is not cleared.
// A stalled output holds the scoring stage, which in turn holds the input.
module gesture_template_matcher_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic                          first_sample,
	input  logic signed [15:0]            accel_x,
	input  logic signed [15:0]            accel_y,
	input  logic signed [15:0]            accel_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [9:0]                    sample_index,
	output logic [1:0]                    axes_matched,
	output logic [11:0]                   match_total,
	output logic                          sequence_done,
	output logic                          gesture_accepted,
	output logic                          template_ready,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gtm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);
	import gtm_pkg::*;

	logic [15:0]        tol_q;
	logic [TOTAL_W-1:0] min_q;
	logic [IDX_W-1:0]   pos_q;
	logic               tvalid_q;
	logic               valid_s1;
	s1_t                word_s1;

	logic               in_acc;
	logic               adv;
	logic [IDX_W-1:0]   idx;
	logic               last;
	logic               chk;
	logic               done;
	logic               tvalid_nxt;
	logic [ENTRY_W-1:0] entry;
	result_t            res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 16'd4915;
			min_q <= TOTAL_W'(128);
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_TOLERANCE:   tol_q <= cfg_data;
				REG_MIN_MATCHES: min_q <= cfg_data[TOTAL_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready   = !valid_s1 || adv;
	assign in_acc     = in_valid && in_ready;
	assign idx        = first_sample ? '0 : pos_q;
	assign last       = idx == LAST_IDX;
	assign chk        = func_t'(func) == FUNC_CHECK;
	// A check with no stored template ends its sequence at once.
	assign done       = last || (chk && !tvalid_q);
	assign tvalid_nxt = chk ? tvalid_q : last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			tvalid_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_acc) begin
				pos_q    <= done ? '0 : idx + IDX_W'(1);
				tvalid_q <= tvalid_nxt;
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			word_s1.compare <= chk && tvalid_q;
			word_s1.clear   <= first_sample;
			word_s1.idx     <= idx;
			word_s1.done    <= done;
			word_s1.tready  <= tvalid_nxt;
			word_s1.x       <= accel_x;
			word_s1.y       <= accel_y;
			word_s1.z       <= accel_z;
		end
	end

	gtm_template_mem u_mem (
		.clk   (clk),
		.we    (in_acc && !chk),
		.re    (in_acc && chk && tvalid_q),
		.addr  (idx),
		.wdata ({accel_z, accel_y, accel_x}),
		.rdata (entry)
	);

	gtm_score u_score (
		.clk         (clk),
		.arst_n      (arst_n),
		.s1          (word_s1),
		.valid_s1    (valid_s1),
		.entry       (entry),
		.tol         (tol_q),
		.min_matches (min_q),
		.adv         (adv),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.res         (res)
	);

	assign sample_index     = res.sample_index;
	assign axes_matched     = res.axes_matched;
	assign match_total      = res.match_total;
	assign sequence_done    = res.sequence_done;
	assign gesture_accepted = res.gesture_accepted;
	assign template_ready   = res.template_ready;

endmodule

@@ src/gtm_checker.sv @@
// Port-level checks for the gesture template matcher, bound to the top level.
// Sees only the top level's ports; uses gtm_pkg for the sequence length.
module gtm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [9:0]  sample_index,
	input logic [1:0]  axes_matched,
	input logic [11:0] match_total,
	input logic        sequence_done,
	input logic        gesture_accepted,
	input logic        template_ready
);
	import gtm_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(match_total))
		else $error("output word dropped or changed while stalled");

	a_accept_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && gesture_accepted |-> sequence_done && template_ready)
		else $error("gesture accepted outside the end of a valid check");

	a_total_covers_axes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {10'd0, axes_matched} <= match_total)
		else $error("running total smaller than this word's matched axes");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sample_index <= 10'(SEQ_LEN - 1))
		else $error("sample index beyond sequence length");

endmodule

bind gesture_template_matcher_core gtm_checker u_gtm_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for gesture_template_matcher_core: directed table, then random
// record and check passes under several register settings, each result checked in order.
// Depends on gtm_pkg and the RTL of the block only.
module tb;
	import gtm_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              func;
	logic              first_sample;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic              out_valid;
	logic              out_ready;
	logic [9:0]        sample_index;
	logic [1:0]        axes_matched;
	logic [11:0]       match_total;
	logic              sequence_done;
	logic              gesture_accepted;
	logic              template_ready;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]       cfg_data;

	gesture_template_matcher_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.first_sample(first_sample),
		.accel_x(accel_x),
		.accel_y(accel_y),
		.accel_z(accel_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_index(sample_index),
		.axes_matched(axes_matched),
		.match_total(match_total),
		.sequence_done(sequence_done),
		.gesture_accepted(gesture_accepted),
		.template_ready(template_ready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	typedef struct {
		func_t              f;
		logic               first;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		int                 rep;
		bit                 typed;
		result_t            want;
	} step_row_t;

	// Mirror of the matcher state.
	logic signed [15:0] tmpl [SEQ_LEN][3];
	int                 seq_pos = 0;
	logic [11:0]        run_total = '0;
	bit                 tmpl_valid = 1'b0;
	logic [15:0]        tol_cfg = 16'd4915;
	logic [11:0]        min_cfg = 12'd128;

	result_t   pending_results [$];
	step_row_t plan [$];
	int        fails = 0;
	bit        no_idle = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic report(string what);
		$display("[%0t] mismatch: %s", $time, what);
		fails++;
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want)
			report($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	function automatic int pause_len();
		if (no_idle)
			return 0;
		return $urandom_range(0, 9);
	endfunction

	// Scores one sample against the mirrored template and advances the mirror.
	function automatic result_t score_sample(func_t f, logic first, logic signed [15:0] sx,
			logic signed [15:0] sy, logic signed [15:0] sz);
		result_t            r;
		logic signed [15:0] s [3];
		int                 idx;
		int                 d;
		logic [1:0]         hits;
		r = '0;
		s[0] = sx;
		s[1] = sy;
		s[2] = sz;
		if (first || seq_pos >= SEQ_LEN) begin
			seq_pos = 0;
			run_total = '0;
		end
		idx = seq_pos;
		r.sample_index = OUT_IDX_W'(idx);
		r.sequence_done = (idx == SEQ_LEN - 1);
		if (f == FUNC_RECORD) begin
			for (int k = 0; k < 3; k++)
				tmpl[idx][k] = s[k];
			run_total = '0;
			tmpl_valid = r.sequence_done;
		end else if (!tmpl_valid) begin
			// A check with no template ends the sequence on the spot.
			r.sequence_done = 1'b1;
		end else begin
			hits = '0;
			for (int k = 0; k < 3; k++) begin
				d = int'(s[k]) - int'(tmpl[idx][k]);
				if (d < 0)
					d = -d;
				if (d <= int'(tol_cfg))
					hits++;
			end
			run_total = run_total + 12'(hits);
			r.axes_matched = hits;
			r.match_total = run_total;
			r.gesture_accepted = r.sequence_done && (run_total >= min_cfg);
		end
		if (r.sequence_done) begin
			seq_pos = 0;
			run_total = '0;
		end else begin
			seq_pos = idx + 1;
		end
		r.template_ready = tmpl_valid;
		return r;
	endfunction

	// Picks an axis value near a template value, often right at the tolerance edge.
	function automatic logic signed [15:0] near(logic signed [15:0] ref_v);
		int delta;
		int t;
		t = int'(tol_cfg);
		case ($urandom_range(0, 4))
			0: delta = 0;
			1: delta = t;
			2: delta = t + 1;
			3: delta = $urandom_range(0, 2 * t + 2);
			default: delta = $urandom_range(0, 65535);
		endcase
		if ($urandom_range(0, 1) == 1)
			delta = -delta;
		return 16'(int'(ref_v) + delta);
	endfunction

	function automatic logic signed [15:0] sample_value(bit wide);
		if (wide)
			return 16'($urandom);
		return 16'($urandom_range(0, 400) - 200);
	endfunction

	task automatic add_row(func_t f, logic first, int x, int y, int z, int rep, bit typed,
			int idx, bit done, bit rdy);
		step_row_t row;
		row.f = f;
		row.first = first;
		row.x = 16'(x);
		row.y = 16'(y);
		row.z = 16'(z);
		row.rep = rep;
		row.typed = typed;
		row.want = '0;
		row.want.sample_index = OUT_IDX_W'(idx);
		row.want.sequence_done = done;
		row.want.template_ready = rdy;
		plan.push_back(row);
	endtask

	// Entered at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_word(func_t f, logic first, logic signed [15:0] x,
			logic signed [15:0] y, logic signed [15:0] z, result_t want);
		int gap;
		gap = pause_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		func <= f;
		first_sample <= first;
		accel_x <= x;
		accel_y <= y;
		accel_z <= z;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(want);
		@(negedge clk);
	endtask

	task automatic issue(func_t f, logic first, logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z);
		result_t want;
		want = score_sample(f, first, x, y, z);
		send_word(f, first, x, y, z, want);
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last write.
	task automatic write_reg(cfg_reg_t which, logic [15:0] value);
		cfg_index <= which;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (which == REG_TOLERANCE)
			tol_cfg = value;
		else
			min_cfg = value[11:0];
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Result side: random back-pressure, in-order compare.
	initial begin
		result_t want;
		int      stall;
		out_ready = 1'b0;
		forever begin
			stall = pause_len();
			if (stall != 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid === 1'b1 && out_ready));
			if (pending_results.size() == 0) begin
				report($sformatf("result at index %0d with nothing expected", sample_index));
			end else begin
				want = pending_results.pop_front();
				check_field("sample_index", int'(sample_index), int'(want.sample_index));
				check_field("axes_matched", int'(axes_matched), int'(want.axes_matched));
				check_field("match_total", int'(match_total), int'(want.match_total));
				check_field("sequence_done", int'(sequence_done), int'(want.sequence_done));
				check_field("gesture_accepted", int'(gesture_accepted),
					int'(want.gesture_accepted));
				check_field("template_ready", int'(template_ready),
					int'(want.template_ready));
			end
		end
	end

	initial begin
		result_t     want;
		int          sent;
		int          len;
		int          kind;
		int          n;
		int          tol;
		int          minv;
		bit          wide;
		in_valid = 1'b0;
		func = FUNC_RECORD;
		first_sample = 1'b0;
		accel_x = '0;
		accel_y = '0;
		accel_z = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_TOLERANCE;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Defaults in force: tolerance 4915 counts, 128 matches to accept.
		add_row(FUNC_CHECK, 1, 0, 0, 0, 1, 1, 0, 1, 0);
		add_row(FUNC_CHECK, 0, -1, -1, -1, 1, 1, 0, 1, 0);
		add_row(FUNC_RECORD, 1, -32768, 32767, 0, 1, 1, 0, 0, 0);
		add_row(FUNC_RECORD, 0, 0, 0, 0, 47, 0, 0, 0, 0);
		add_row(FUNC_RECORD, 0, 100, -100, 4915, 1, 0, 0, 0, 0);
		add_row(FUNC_RECORD, 0, -1, 1, -32768, 1, 1, 49, 1, 1);
		// Full-scale differences miss, a difference equal to the tolerance hits.
		add_row(FUNC_CHECK, 1, 32767, -32768, 4915, 1, 0, 0, 0, 0);
		add_row(FUNC_CHECK, 0, 4915, -4915, 4916, 1, 0, 0, 0, 0);
		add_row(FUNC_CHECK, 0, 0, 0, 0, 46, 0, 0, 0, 0);
		add_row(FUNC_CHECK, 0, 5015, -5015, 0, 1, 0, 0, 0, 0);
		add_row(FUNC_CHECK, 0, 32767, -32768, 32767, 1, 0, 0, 0, 0);
		// A record word in the middle of a check drops the template.
		add_row(FUNC_CHECK, 1, -32768, 32767, 0, 1, 0, 0, 0, 0);
		add_row(FUNC_RECORD, 0, 0, 0, 0, 1, 1, 1, 0, 0);
		add_row(FUNC_CHECK, 0, 0, 0, 0, 1, 1, 2, 1, 0);
		add_row(FUNC_CHECK, 0, 0, 0, 0, 1, 1, 0, 1, 0);
		// Restart a recording part way through, then finish it.
		add_row(FUNC_RECORD, 1, 1, 2, 3, 1, 0, 0, 0, 0);
		add_row(FUNC_RECORD, 0, 4, 5, 6, 1, 0, 0, 0, 0);
		add_row(FUNC_RECORD, 1, 7, 8, 9, 1, 1, 0, 0, 0);
		add_row(FUNC_RECORD, 0, 12345, -12345, 32767, 48, 0, 0, 0, 0);
		add_row(FUNC_RECORD, 0, 0, 0, 0, 1, 1, 49, 1, 1);
		// A poor check that ends below the minimum.
		add_row(FUNC_CHECK, 1, 4923, -4908, 9, 1, 0, 0, 0, 0);
		add_row(FUNC_CHECK, 0, 0, 0, 0, 48, 0, 0, 0, 0);
		add_row(FUNC_CHECK, 0, 0, 0, 0, 1, 0, 0, 0, 0);

		foreach (plan[r]) begin
			repeat (plan[r].rep) begin
				no_idle = ($urandom_range(0, 4) == 0);
				want = score_sample(plan[r].f, plan[r].first, plan[r].x, plan[r].y, plan[r].z);
				if (plan[r].typed)
					want = plan[r].want;
				send_word(plan[r].f, plan[r].first, plan[r].x, plan[r].y, plan[r].z, want);
			end
		end

		// Every template entry has been written by now, so checks never read stale memory.
		for (int phase = 0; phase < 9; phase++) begin
			drain();
			case (phase)
				0: begin
					tol = 0;
					minv = 0;
				end
				1: begin
					tol = 65535;
					minv = 3072;
				end
				2: begin
					tol = 4915;
					minv = 128;
				end
				3: begin
					tol = 1;
					minv = 150;
				end
				default: begin
					tol = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
						: $urandom_range(0, 6000);
					minv = $urandom_range(0, 150);
				end
			endcase
			write_reg(REG_TOLERANCE, 16'(tol));
			write_reg(REG_MIN_MATCHES, 16'(minv));
			cfg_valid <= 1'b0;

			sent = 0;
			while (sent < 195) begin
				no_idle = ($urandom_range(0, 4) == 0);
				kind = $urandom_range(0, 99);
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, SEQ_LEN - 1) : SEQ_LEN;
				if (kind < 70 && tmpl_valid) begin
					for (int i = 0; i < len; i++)
						issue(FUNC_CHECK, i == 0, near(tmpl[i][0]), near(tmpl[i][1]),
							near(tmpl[i][2]));
					sent += len;
				end else if (kind < 88 || !tmpl_valid) begin
					wide = ($urandom_range(0, 1) == 1);
					for (int i = 0; i < len; i++)
						issue(FUNC_RECORD, i == 0, sample_value(wide), sample_value(wide),
							sample_value(wide));
					sent += len;
				end else begin
					n = $urandom_range(1, 8);
					for (int i = 0; i < n; i++)
						issue(func_t'(1'($urandom_range(0, 1))), $urandom_range(0, 3) == 0,
							16'($urandom), 16'($urandom), 16'($urandom));
					sent += n;
				end
			end
		end

		drain();
		repeat (8) @(negedge clk);
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ gesture_template_matcher_core.f @@
src/gtm_pkg.sv
src/gtm_template_mem.sv
src/gtm_score.sv
src/gesture_template_matcher_core.sv
src/gtm_checker.sv
tb/tb.sv
